// ===== src/mtpb_pkg.sv =====
// Package for the mode tree probability builder.
// Holds widths, counts and the sequencer state type; depends on nothing.
`default_nettype none

package mtpb_pkg;

    localparam int NUM_MODES = 10;
    localparam int PER_TYPE  = 2 * NUM_MODES;
    localparam int NUM_NODES = 10;
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 15;
    localparam int SUM_W     = 18;
    localparam int NUM_W     = 26;
    localparam int QUOT_W    = 8;
    localparam int IDX_W     = 4;
    localparam int READS     = 12;
    localparam int SLOT_S    = 10;
    localparam int SLOT_O    = 11;
    localparam int COUNT_MUL = 100;
    localparam int PROB_MAX  = 255;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_GROUP = 5'b00100,
        S_LOAD  = 5'b01000,
        S_DIV   = 5'b10000
    } t_state;

endpackage

`default_nettype wire

// ===== src/mode_tree_probability_builder_top.sv =====
// Top level of the mode tree probability builder: probability table and query sequencer.
// Depends on mtpb_pkg and on the serial divider mtpb_div.
//
// A write transaction (i_mode low) stores one table byte in the cycle it is accepted and
// gives no result; busy stays low, so writes may follow every cycle. A query transaction
// (i_mode high) reads twelve table bytes, then runs ten eight-step divisions one after
// another on the single serial divider; busy is high while the query runs and falls
// as o_done rises. Results appear for exactly one cycle with o_done and the receiver
// cannot stall them. The table clears to zero at reset through per-entry valid flags,
// so no clearing pass is needed.
`default_nettype none

module mode_tree_probability_builder_top #(
    parameter int MODE_TYPES = 3
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    output logic            o_busy,
    input  wire logic       i_mode,
    input  wire logic [1:0] i_type_index,
    input  wire logic       i_side,
    input  wire logic [3:0] i_mode_index,
    input  wire logic [7:0] i_value,
    output logic            o_done,
    output logic [7:0]      o_prob_repeat,
    output logic [7:0]      o_node0_prob,
    output logic [7:0]      o_node1_prob,
    output logic [7:0]      o_node2_prob,
    output logic [7:0]      o_node3_prob,
    output logic [7:0]      o_node4_prob,
    output logic [7:0]      o_node5_prob,
    output logic [7:0]      o_node6_prob,
    output logic [7:0]      o_node7_prob,
    output logic [7:0]      o_node8_prob
);

    localparam int DEPTH = MODE_TYPES * mtpb_pkg::PER_TYPE;
    localparam int AW    = $clog2(DEPTH);

    mtpb_pkg::t_state r_state, n_state;

    logic [mtpb_pkg::BYTE_W-1:0]  mem [DEPTH];
    logic [DEPTH-1:0]             r_vld;
    logic [mtpb_pkg::BYTE_W-1:0]  r_rd_data;
    logic                         r_rd_vld;

    logic [1:0]                   r_type;
    logic [3:0]                   r_midx;
    logic                         r_type_ok;
    logic                         r_midx_ok;
    logic [mtpb_pkg::IDX_W-1:0]   r_idx;
    logic [mtpb_pkg::IDX_W-1:0]   r_node;
    logic [mtpb_pkg::COUNT_W-1:0] r_cnt [mtpb_pkg::NUM_MODES];
    logic [mtpb_pkg::BYTE_W-1:0]  r_s;
    logic [mtpb_pkg::BYTE_W-1:0]  r_o;
    logic [mtpb_pkg::SUM_W-1:0]   r_g02, r_g34, r_g17, r_g56, r_g89;
    logic [mtpb_pkg::BYTE_W-1:0]  r_res [mtpb_pkg::NUM_NODES];
    logic                         r_done;

    logic                         accept;
    logic                         wr_type_ok;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [AW-1:0]                base;
    logic [AW-1:0]                rd_addr;
    logic [mtpb_pkg::BYTE_W-1:0]  rd_byte;
    logic [mtpb_pkg::IDX_W-1:0]   cap_k;
    logic [mtpb_pkg::SUM_W-1:0]   part, whole;
    logic [mtpb_pkg::NUM_W-1:0]   div_num;
    logic [mtpb_pkg::SUM_W-1:0]   div_den;
    logic                         div_start;
    logic                         div_done;
    logic [mtpb_pkg::QUOT_W-1:0]  div_quot;

    assign accept     = i_start && !o_busy;
    assign wr_type_ok = (32'(i_type_index) < MODE_TYPES);
    assign wr_en      = accept && !i_mode && wr_type_ok &&
                        (32'(i_mode_index) < mtpb_pkg::NUM_MODES);
    assign wr_addr    = wr_type_ok ?
        AW'(32'(i_type_index) * mtpb_pkg::PER_TYPE + 32'(i_side) * mtpb_pkg::NUM_MODES
            + 32'(i_mode_index)) : '0;

    assign base = r_type_ok ? AW'(32'(r_type) * mtpb_pkg::PER_TYPE) : '0;

    always_comb begin
        rd_addr = '0;
        if (r_type_ok) begin
            if (32'(r_idx) < mtpb_pkg::NUM_MODES) begin
                rd_addr = base + AW'(r_idx);
            end else if (r_midx_ok && 32'(r_idx) == mtpb_pkg::SLOT_S) begin
                rd_addr = base + AW'(mtpb_pkg::NUM_MODES) + AW'(r_midx);
            end else if (r_midx_ok && 32'(r_idx) == mtpb_pkg::SLOT_O) begin
                rd_addr = base + AW'(r_midx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_value;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[rd_addr];
        end
    end

    assign rd_byte = (r_rd_vld && r_type_ok) ? r_rd_data : '0;
    assign cap_k   = r_idx - mtpb_pkg::IDX_W'(1);

    always_comb begin
        part  = '0;
        whole = '0;
        case (r_node)
            4'd1: begin
                part  = r_g02 + r_g34;
                whole = r_g02 + r_g34 + r_g17 + r_g56 + r_g89;
            end
            4'd2: begin
                part  = r_g02;
                whole = r_g02 + r_g34;
            end
            4'd3: begin
                part  = r_g17;
                whole = r_g17 + r_g56 + r_g89;
            end
            4'd4: begin
                part  = mtpb_pkg::SUM_W'(r_cnt[0]);
                whole = r_g02;
            end
            4'd5: begin
                part  = mtpb_pkg::SUM_W'(r_cnt[3]);
                whole = r_g34;
            end
            4'd6: begin
                part  = mtpb_pkg::SUM_W'(r_cnt[1]);
                whole = r_g17;
            end
            4'd7: begin
                part  = r_g56;
                whole = r_g56 + r_g89;
            end
            4'd8: begin
                part  = mtpb_pkg::SUM_W'(r_cnt[5]);
                whole = r_g56;
            end
            4'd9: begin
                part  = mtpb_pkg::SUM_W'(r_cnt[8]);
                whole = r_g89;
            end
            default: begin
                part  = mtpb_pkg::SUM_W'(r_s);
                whole = mtpb_pkg::SUM_W'(r_s) + mtpb_pkg::SUM_W'(r_o);
            end
        endcase
    end

    assign div_num   = (mtpb_pkg::NUM_W'(part) << 8) - mtpb_pkg::NUM_W'(part);
    assign div_den   = whole + mtpb_pkg::SUM_W'(1);
    assign div_start = (r_state == mtpb_pkg::S_LOAD);

    mtpb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            mtpb_pkg::S_IDLE: begin
                if (accept && i_mode) begin
                    n_state = mtpb_pkg::S_READ;
                end
            end
            mtpb_pkg::S_READ: begin
                if (32'(r_idx) == mtpb_pkg::READS) begin
                    n_state = mtpb_pkg::S_GROUP;
                end
            end
            mtpb_pkg::S_GROUP: n_state = mtpb_pkg::S_LOAD;
            mtpb_pkg::S_LOAD:  n_state = mtpb_pkg::S_DIV;
            mtpb_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = (32'(r_node) == mtpb_pkg::NUM_NODES - 1) ?
                              mtpb_pkg::S_IDLE : mtpb_pkg::S_LOAD;
                end
            end
            default: n_state = mtpb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtpb_pkg::S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == mtpb_pkg::S_DIV) && div_done &&
                       (32'(r_node) == mtpb_pkg::NUM_NODES - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            mtpb_pkg::S_IDLE: begin
                if (accept && i_mode) begin
                    r_type    <= i_type_index;
                    r_midx    <= i_mode_index;
                    r_type_ok <= wr_type_ok;
                    r_midx_ok <= (32'(i_mode_index) < mtpb_pkg::NUM_MODES);
                    r_idx     <= '0;
                end
            end
            mtpb_pkg::S_READ: begin
                r_idx <= r_idx + mtpb_pkg::IDX_W'(1);
                if (r_idx != '0) begin
                    if (32'(cap_k) < mtpb_pkg::NUM_MODES) begin
                        r_cnt[cap_k] <= (cap_k == r_midx) ? '0 :
                            mtpb_pkg::COUNT_W'(rd_byte) *
                            mtpb_pkg::COUNT_W'(mtpb_pkg::COUNT_MUL);
                    end else if (32'(cap_k) == mtpb_pkg::SLOT_S) begin
                        r_s <= r_midx_ok ? rd_byte : '0;
                    end else begin
                        r_o <= r_midx_ok ? rd_byte : '0;
                    end
                end
            end
            mtpb_pkg::S_GROUP: begin
                r_g02  <= mtpb_pkg::SUM_W'(r_cnt[0]) + mtpb_pkg::SUM_W'(r_cnt[2]);
                r_g34  <= mtpb_pkg::SUM_W'(r_cnt[3]) + mtpb_pkg::SUM_W'(r_cnt[4]);
                r_g17  <= mtpb_pkg::SUM_W'(r_cnt[1]) + mtpb_pkg::SUM_W'(r_cnt[7]);
                r_g56  <= mtpb_pkg::SUM_W'(r_cnt[5]) + mtpb_pkg::SUM_W'(r_cnt[6]);
                r_g89  <= mtpb_pkg::SUM_W'(r_cnt[8]) + mtpb_pkg::SUM_W'(r_cnt[9]);
                r_node <= '0;
            end
            mtpb_pkg::S_DIV: begin
                if (div_done) begin
                    r_res[r_node] <= (r_node == '0) ?
                        mtpb_pkg::BYTE_W'(mtpb_pkg::PROB_MAX) - div_quot :
                        div_quot + mtpb_pkg::BYTE_W'(1);
                    r_node <= r_node + mtpb_pkg::IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_busy        = (r_state != mtpb_pkg::S_IDLE);
    assign o_done        = r_done;
    assign o_prob_repeat = r_res[0];
    assign o_node0_prob  = r_res[1];
    assign o_node1_prob  = r_res[2];
    assign o_node2_prob  = r_res[3];
    assign o_node3_prob  = r_res[4];
    assign o_node4_prob  = r_res[5];
    assign o_node5_prob  = r_res[6];
    assign o_node6_prob  = r_res[7];
    assign o_node7_prob  = r_res[8];
    assign o_node8_prob  = r_res[9];

    // A result is only ever announced right after the last division finished.
    a_done_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == mtpb_pkg::S_DIV) && $past(div_done))
        else $error("result strobe without a finished division");

    // An accepted query always makes the block busy in the next cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_mode) |=> o_busy)
        else $error("query accepted but block not busy");

    // The divider only completes while the sequencer waits for it.
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == mtpb_pkg::S_DIV))
        else $error("divider finished outside the division state");

    // Branch probabilities are never zero.
    a_node_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_node0_prob != 8'd0) && (o_node4_prob != 8'd0) &&
                   (o_node8_prob != 8'd0))
        else $error("zero branch probability");

endmodule

`default_nettype wire

// ===== src/mtpb_div.sv =====
// Serial restoring divider that delivers an eight-bit quotient, one bit per cycle.
// Depends on mtpb_pkg for its operand widths.
`default_nettype none

module mtpb_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [mtpb_pkg::NUM_W-1:0]  i_num,
    input  wire logic [mtpb_pkg::SUM_W-1:0]  i_den,
    output logic                             o_done,
    output logic [mtpb_pkg::QUOT_W-1:0]      o_quot
);

    logic [mtpb_pkg::NUM_W-1:0]  r_rem;
    logic [mtpb_pkg::NUM_W-1:0]  r_dsh;
    logic [mtpb_pkg::QUOT_W-1:0] r_q;
    logic [2:0]                  r_step;
    logic                        r_run;
    logic                        r_done;
    logic                        take;

    assign take = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= 3'd7;
            end else if (r_run) begin
                r_step <= r_step - 3'd1;
                if (r_step == 3'd0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= mtpb_pkg::NUM_W'(i_den) << 7;
            r_q   <= '0;
        end else if (r_run) begin
            if (take) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[mtpb_pkg::QUOT_W-2:0], take};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// ===== test/mode_tree_probability_builder_top_tb.sv =====
// Self-checking testbench for mode_tree_probability_builder_top: table writes and probability queries.
// Depends on mtpb_pkg and the RTL of the block; an internal model of the table predicts every result.
`default_nettype none

module mode_tree_probability_builder_top_tb;

    localparam int TB_MODE_TYPES = 3;
    localparam int NUM_ITEMS     = 400;
    localparam int DRAIN_CYCLES  = 150;
    localparam int CYCLE_LIMIT   = 500000;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] type_index;
        logic       side;
        logic [3:0] mode_index;
        logic [7:0] value;
    } t_cmd;

    typedef struct packed {
        logic [7:0]      repeat_prob;
        logic [8:0][7:0] node;
    } t_probs;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_start = 1'b0;
    logic       i_mode = 1'b0;
    logic [1:0] i_type_index = 2'd0;
    logic       i_side = 1'b0;
    logic [3:0] i_mode_index = 4'd0;
    logic [7:0] i_value = 8'd0;
    logic       o_busy;
    logic       o_done;
    logic [7:0] o_prob_repeat;
    logic [7:0] o_node0_prob, o_node1_prob, o_node2_prob, o_node3_prob, o_node4_prob;
    logic [7:0] o_node5_prob, o_node6_prob, o_node7_prob, o_node8_prob;

    t_cmd   pending_cmds[$];
    t_probs expected_probs[$];
    logic [7:0] prob_bytes [TB_MODE_TYPES * mtpb_pkg::PER_TYPE];

    int total_cmds = 0;
    int accepted_cmds = 0;
    int write_count = 0;
    int query_count = 0;
    int checked_results = 0;
    int fail_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int cycle_count = 0;

    mode_tree_probability_builder_top #(.MODE_TYPES(TB_MODE_TYPES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_mode(i_mode), .i_type_index(i_type_index), .i_side(i_side),
        .i_mode_index(i_mode_index), .i_value(i_value), .o_done(o_done),
        .o_prob_repeat(o_prob_repeat),
        .o_node0_prob(o_node0_prob), .o_node1_prob(o_node1_prob),
        .o_node2_prob(o_node2_prob), .o_node3_prob(o_node3_prob),
        .o_node4_prob(o_node4_prob), .o_node5_prob(o_node5_prob),
        .o_node6_prob(o_node6_prob), .o_node7_prob(o_node7_prob),
        .o_node8_prob(o_node8_prob)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [7:0] branch_prob(int unsigned part, int unsigned whole);
        int unsigned q;
        q = 1 + (mtpb_pkg::PROB_MAX * part) / (1 + whole);
        return q[7:0];
    endfunction

    function automatic t_probs compute_tree_probs(t_cmd cmd);
        int unsigned cnt [mtpb_pkg::NUM_MODES];
        int unsigned total;
        int unsigned s;
        int unsigned o;
        int unsigned rep;
        logic type_ok;
        t_probs r;
        total = 0;
        s = 0;
        o = 0;
        type_ok = cmd.type_index < TB_MODE_TYPES;
        for (int j = 0; j < mtpb_pkg::NUM_MODES; j++) begin
            if (!type_ok || j == cmd.mode_index) begin
                cnt[j] = 0;
            end else begin
                cnt[j] = mtpb_pkg::COUNT_MUL *
                         prob_bytes[cmd.type_index * mtpb_pkg::PER_TYPE + j];
            end
            total += cnt[j];
        end
        if (type_ok && cmd.mode_index < mtpb_pkg::NUM_MODES) begin
            s = prob_bytes[cmd.type_index * mtpb_pkg::PER_TYPE + mtpb_pkg::NUM_MODES
                           + cmd.mode_index];
            o = prob_bytes[cmd.type_index * mtpb_pkg::PER_TYPE + cmd.mode_index];
        end
        rep = mtpb_pkg::PROB_MAX - (mtpb_pkg::PROB_MAX * s) / (1 + s + o);
        r.repeat_prob = rep[7:0];
        r.node[0] = branch_prob(cnt[0] + cnt[2] + cnt[3] + cnt[4], total);
        r.node[1] = branch_prob(cnt[0] + cnt[2], cnt[0] + cnt[2] + cnt[3] + cnt[4]);
        r.node[2] = branch_prob(cnt[1] + cnt[7],
                                cnt[1] + cnt[7] + cnt[5] + cnt[6] + cnt[8] + cnt[9]);
        r.node[3] = branch_prob(cnt[0], cnt[0] + cnt[2]);
        r.node[4] = branch_prob(cnt[3], cnt[3] + cnt[4]);
        r.node[5] = branch_prob(cnt[1], cnt[1] + cnt[7]);
        r.node[6] = branch_prob(cnt[5] + cnt[6], cnt[5] + cnt[6] + cnt[8] + cnt[9]);
        r.node[7] = branch_prob(cnt[5], cnt[5] + cnt[6]);
        r.node[8] = branch_prob(cnt[8], cnt[8] + cnt[9]);
        return r;
    endfunction

    task automatic apply_cmd(t_cmd cmd);
        if (cmd.op == OP_WRITE) begin
            write_count++;
            if (cmd.type_index < TB_MODE_TYPES && cmd.mode_index < mtpb_pkg::NUM_MODES) begin
                prob_bytes[cmd.type_index * mtpb_pkg::PER_TYPE
                           + cmd.side * mtpb_pkg::NUM_MODES + cmd.mode_index] = cmd.value;
            end
        end else begin
            query_count++;
            expected_probs.push_back(compute_tree_probs(cmd));
        end
    endtask

    task automatic add_cmd(t_op op, int ti, int sd, int mi, int val);
        t_cmd c;
        c.op = op;
        c.type_index = ti[1:0];
        c.side = sd[0];
        c.mode_index = mi[3:0];
        c.value = val[7:0];
        pending_cmds.push_back(c);
        total_cmds++;
    endtask

    function automatic int pick_type();
        return ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, TB_MODE_TYPES - 1);
    endfunction

    function automatic int pick_mode();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(mtpb_pkg::NUM_MODES, 15)
                                            : $urandom_range(0, mtpb_pkg::NUM_MODES - 1);
    endfunction

    function automatic int pick_value();
        int k;
        k = $urandom_range(0, 19);
        if (k < 3) begin
            return 0;
        end else if (k < 6) begin
            return mtpb_pkg::PROB_MAX;
        end
        return $urandom_range(0, mtpb_pkg::PROB_MAX);
    endfunction

    // Sender: bursts of transactions separated by random gaps; an offer held while busy.
    always @(posedge i_clk) begin
        t_cmd c;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                c.op = t_op'(i_mode);
                c.type_index = i_type_index;
                c.side = i_side;
                c.mode_index = i_mode_index;
                c.value = i_value;
                apply_cmd(c);
                accepted_cmds++;
            end
            if (i_start && o_busy) begin
                i_start <= 1'b1;
            end else if (gap_left != 0) begin
                gap_left--;
                i_start <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                c = pending_cmds.pop_front();
                i_mode <= c.op;
                i_type_index <= c.type_index;
                i_side <= c.side;
                i_mode_index <= c.mode_index;
                i_value <= c.value;
                i_start <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // Monitor: every o_done strobe is one result transaction.
    always @(posedge i_clk) begin
        t_probs got;
        t_probs want;
        if (i_rst_n && o_done) begin
            got.repeat_prob = o_prob_repeat;
            got.node = {o_node8_prob, o_node7_prob, o_node6_prob, o_node5_prob,
                        o_node4_prob, o_node3_prob, o_node2_prob, o_node1_prob,
                        o_node0_prob};
            if (expected_probs.size() == 0) begin
                $error("result transaction with no query outstanding");
                fail_count++;
            end else begin
                want = expected_probs.pop_front();
                checked_results++;
                if (got.repeat_prob !== want.repeat_prob) begin
                    $error("prob_repeat expected %0d got %0d", want.repeat_prob,
                           got.repeat_prob);
                    fail_count++;
                end
                for (int k = 0; k < 9; k++) begin
                    if (got.node[k] !== want.node[k]) begin
                        $error("node%0d_prob expected %0d got %0d", k, want.node[k],
                               got.node[k]);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("mode_tree_probability_builder_top: mismatch");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < TB_MODE_TYPES * mtpb_pkg::PER_TYPE; i++) begin
            prob_bytes[i] = 8'd0;
        end

        // Directed: empty table, out-of-range contexts, saturated bytes, ignored writes.
        add_cmd(OP_QUERY, 0, 0, 0, 0);
        add_cmd(OP_QUERY, 3, 1, 15, 255);
        add_cmd(OP_WRITE, 0, 0, 0, 255);
        add_cmd(OP_WRITE, 0, 0, 1, 255);
        add_cmd(OP_WRITE, 0, 0, 5, 255);
        add_cmd(OP_WRITE, 0, 0, 8, 255);
        add_cmd(OP_WRITE, 0, 1, 3, 255);
        add_cmd(OP_WRITE, 3, 1, 2, 8'haa);
        add_cmd(OP_WRITE, 1, 0, 12, 8'h55);
        add_cmd(OP_QUERY, 0, 0, 0, 0);
        add_cmd(OP_QUERY, 0, 1, 3, 255);
        add_cmd(OP_QUERY, 0, 0, 11, 0);
        add_cmd(OP_QUERY, 3, 0, 1, 0);
        add_cmd(OP_QUERY, 1, 0, 2, 0);
        add_cmd(OP_WRITE, 2, 1, 9, 0);
        add_cmd(OP_WRITE, 2, 0, 9, 1);
        add_cmd(OP_WRITE, 2, 0, 4, 255);
        add_cmd(OP_QUERY, 2, 0, 9, 0);
        add_cmd(OP_QUERY, 2, 0, 4, 0);
        add_cmd(OP_QUERY, 2, 1, 0, 0);

        while (total_cmds < NUM_ITEMS) begin
            if ($urandom_range(0, 99) < 65) begin
                add_cmd(OP_WRITE, pick_type(), $urandom_range(0, 1), pick_mode(),
                        pick_value());
            end else begin
                add_cmd(OP_QUERY, pick_type(), $urandom_range(0, 1), pick_mode(),
                        $urandom_range(0, 255));
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_cmds < total_cmds) @(negedge i_clk);
        while (expected_probs.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (expected_probs.size() != 0) begin
            $error("%0d query results never arrived", expected_probs.size());
            fail_count++;
        end
        $display("Ran %0d writes and %0d queries, checked %0d result transactions.",
                 write_count, query_count, checked_results);
        if (fail_count == 0) begin
            $display("mode_tree_probability_builder_top: match");
        end else begin
            $display("mode_tree_probability_builder_top: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/mtpb_pkg.sv
src/mtpb_div.sv
src/mode_tree_probability_builder_top.sv
test/mode_tree_probability_builder_top_tb.sv
